// ===== hw/rtl/bb3_pkg.sv =====
// Package for the 3x3 RGB box blur: pixel type, line buffer sizing,
// configuration register indexes and the divide-by-nine constants.
// No dependencies.
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int LB_AW     = $clog2(MAX_WIDTH);
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int LB_W      = 2 * PIX_W;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 12;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 10;
    localparam int SUM_W     = 12;
    localparam int CFG_W     = 12;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(3);

    // floor(s/9) == (s * 3641) >> 15 for every s up to 9*255
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W     = 2 * SUM_W;
    localparam logic [SUM_W-1:0] DIV9_MUL = SUM_W'(3641);

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch0;
    } t_pix;

    typedef struct packed {
        t_pix two_up;
        t_pix one_up;
    } t_lb_word;

endpackage

// ===== hw/rtl/bb3_line_buf.sv =====
// Line buffer memory for the 3x3 RGB box blur: one entry per column
// holding the pixels one and two rows up. Depends on bb3_pkg.
module bb3_line_buf
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [LB_AW-1:0] i_rd_addr,
    output t_lb_word         o_rd_data,
    input  logic             i_wr_en,
    input  logic [LB_AW-1:0] i_wr_addr,
    input  t_lb_word         i_wr_data
);

    t_lb_word r_mem [MAX_WIDTH];
    t_lb_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// Top level of the 3x3 RGB box blur: position tracking, window, sum and
// divide-by-nine pipeline. Depends on bb3_pkg and bb3_line_buf.
//
// Pixels enter on the s_axis channel in raster order, one word per pixel.
// Each interior pixel's blurred value leaves on m_axis together with its
// row and column; tlast marks the last interior pixel of the frame. Border
// positions produce no output word.
// The frame size comes from the two configuration registers (width at
// index 0, height at index 1); write them only while the block is idle.
// An output word is registered in the stage 0, stage 1 and stage 2 registers in turn
// once the input word that completes its neighborhood is accepted. Throughput: one
// pixel per cycle unless stalled, set by the single line buffer read port and the
// three-stage pipeline. When m_axis_tready is low while a result waits in the
// output register, the whole pipeline holds and s_axis_tready drops; otherwise
// input keeps flowing.
// Reset clears the position to the top-left pixel, the window to zero and
// the size to 640 x 480. Line buffer contents are not cleared; the top row of
// a frame reads each entry before it is written.
module box_blur_3x3_rgb
    import bb3_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PIX_W-1:0]    s_axis_tdata,   // in_ch0, in_ch1, in_ch2
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [47:0]         m_axis_tdata,   // out_ch0, out_ch1, out_ch2,
                                                // out_row, out_col, zero pad
    output logic                m_axis_tlast    // frame_last
);

    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    logic [ROW_W-1:0] r_row_pos, n_row_pos;
    logic [COL_W-1:0] r_col_pos, n_col_pos;

    logic en, accept;

    // stage 0: accepted pixel plus line buffer read
    logic             r_s0_valid;
    t_pix             r_s0_px;
    logic             r_s0_emit;
    logic             r_s0_last;
    logic [ROW_W-1:0] r_s0_row;
    logic [COL_W-1:0] r_s0_col;
    t_lb_word         lb_rd;
    t_lb_word         lb_wr;
    logic             lb_we;

    t_pix r_win [6];
    t_pix cur [3];

    // stage 1: channel sums
    logic             r_s1_valid;
    logic [SUM_W-1:0] r_s1_sum [3];
    logic             r_s1_last;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    logic [SUM_W-1:0] sum [3];

    // stage 2: output register
    logic             r_s2_valid;
    logic [CH_W-1:0]  r_s2_ch [3];
    logic             r_s2_last;
    logic [ROW_W-1:0] r_s2_row;
    logic [COL_W-1:0] r_s2_col;
    logic [PROD_W-1:0] prod [3];

    logic [WIDTH_W:0]  nc;
    logic [HEIGHT_W:0] nr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (r_frame_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_frame_width;
        end
        h_eff = (r_frame_height < HEIGHT_MIN) ? HEIGHT_MIN : r_frame_height;
    end

    assign en            = !r_s2_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // advance position
    always_comb begin
        n_row_pos = r_row_pos;
        n_col_pos = r_col_pos;
        nc = {1'b0, WIDTH_W'(r_col_pos)} + (WIDTH_W+1)'(1);
        nr = {1'b0, r_row_pos} + (HEIGHT_W+1)'(1);
        if (nc >= {1'b0, w_eff}) begin
            n_col_pos = '0;
            n_row_pos = (nr >= {1'b0, h_eff}) ? '0 : nr[ROW_W-1:0];
        end else if (r_row_pos >= h_eff) begin
            n_row_pos = '0;
            n_col_pos = '0;
        end else begin
            n_col_pos = nc[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (accept) begin
            r_row_pos <= n_row_pos;
            r_col_pos <= n_col_pos;
        end
    end

    bb3_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col_pos),
        .o_rd_data (lb_rd),
        .i_wr_en   (lb_we),
        .i_wr_addr (r_s0_col),
        .i_wr_data (lb_wr)
    );

    assign lb_we        = r_s0_valid && en;
    assign lb_wr.two_up = lb_rd.one_up;
    assign lb_wr.one_up = r_s0_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_px   <= t_pix'(s_axis_tdata);
            r_s0_row  <= r_row_pos;
            r_s0_col  <= r_col_pos;
            r_s0_emit <= (r_row_pos >= ROW_W'(2)) && (r_col_pos >= COL_W'(2));
            r_s0_last <= (r_row_pos == h_eff - HEIGHT_W'(1))
                      && ({1'b0, r_col_pos} == w_eff - WIDTH_W'(1));
        end
    end

    assign cur[0] = lb_rd.two_up;
    assign cur[1] = lb_rd.one_up;
    assign cur[2] = r_s0_px;

    // shift window: column c-1 moves to c-2, current column enters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s0_valid && en) begin
            for (int i = 0; i < 3; i++) begin
                r_win[3+i] <= r_win[i];
                r_win[i]   <= cur[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            sum[0] = sum[0] + SUM_W'(cur[i].ch0) + SUM_W'(r_win[i].ch0)
                   + SUM_W'(r_win[3+i].ch0);
            sum[1] = sum[1] + SUM_W'(cur[i].ch1) + SUM_W'(r_win[i].ch1)
                   + SUM_W'(r_win[3+i].ch1);
            sum[2] = sum[2] + SUM_W'(cur[i].ch2) + SUM_W'(r_win[i].ch2)
                   + SUM_W'(r_win[3+i].ch2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_s0_valid && r_s0_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_sum[i] <= sum[i];
            end
            r_s1_last <= r_s0_last;
            r_s1_row  <= r_s0_row - ROW_W'(1);
            r_s1_col  <= r_s0_col - COL_W'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = PROD_W'(r_s1_sum[i]) * PROD_W'(DIV9_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_ch[i] <= prod[i][DIV9_SHIFT +: CH_W];
            end
            r_s2_last <= r_s1_last;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {2'b00, r_s2_col, r_s2_row, r_s2_ch[2], r_s2_ch[1], r_s2_ch[0]};
    assign m_axis_tlast  = r_s2_last;

endmodule

// ===== dv/box_blur_checker.sv =====
`timescale 1ns / 1ps
// Checker for box_blur_3x3_rgb: tracks the frame position, line buffers and window from the
// accepted input words and config writes, predicts each blurred word and compares it with
// m_axis. Depends on bb3_pkg.
module box_blur_checker
    import bb3_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [PIX_W-1:0]    s_axis_tdata,   // in_ch0, in_ch1, in_ch2
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [47:0]         m_axis_tdata,   // out_ch0, out_ch1, out_ch2,
                                                // out_row, out_col, zero pad
    input  logic                m_axis_tlast,   // frame_last
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_word_count,
    output int                  o_frame_count
);

    typedef struct packed {
        logic [CH_W-1:0]  ch0;
        logic [CH_W-1:0]  ch1;
        logic [CH_W-1:0]  ch2;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_blur_word;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    t_pix                row_one_up [MAX_WIDTH];
    t_pix                row_two_up [MAX_WIDTH];
    t_pix                win_c1 [3];
    t_pix                win_c2 [3];
    logic [ROW_W-1:0]    pos_row;
    int unsigned         pos_col;
    t_blur_word          blur_expect_q [$];
    int                  fail_cnt  = 0;
    int                  word_cnt  = 0;
    int                  frame_cnt = 0;

    task automatic advance_blur(input t_pix px);
        int unsigned w_eff, h_eff, r, c, s0, s1, s2, i;
        t_pix        col_now [3];
        t_blur_word  word;
        if (width_reg < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (width_reg > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
        r = pos_row;
        c = pos_col;
        col_now[0] = row_two_up[c];
        col_now[1] = row_one_up[c];
        col_now[2] = px;
        if (r >= 2 && c >= 2) begin
            s0 = 0;
            s1 = 0;
            s2 = 0;
            for (i = 0; i < 3; i++) begin
                s0 += col_now[i].ch0 + win_c1[i].ch0 + win_c2[i].ch0;
                s1 += col_now[i].ch1 + win_c1[i].ch1 + win_c2[i].ch1;
                s2 += col_now[i].ch2 + win_c1[i].ch2 + win_c2[i].ch2;
            end
            word.ch0  = CH_W'(s0 / 9);
            word.ch1  = CH_W'(s1 / 9);
            word.ch2  = CH_W'(s2 / 9);
            word.row  = ROW_W'(r - 1);
            word.col  = COL_W'(c - 1);
            word.last = (r == h_eff - 1) && (c == w_eff - 1);
            blur_expect_q.push_back(word);
        end
        win_c2 = win_c1;
        win_c1 = col_now;
        row_two_up[c] = row_one_up[c];
        row_one_up[c] = px;
        c++;
        if (c >= w_eff) begin
            c = 0;
            r++;
            if (r >= h_eff) r = 0;
        end else if (r >= h_eff) begin
            r = 0;
            c = 0;
        end
        pos_row = ROW_W'(r);
        pos_col = c;
    endtask

    task automatic check_word();
        t_blur_word want, got;
        got.ch0  = m_axis_tdata[7:0];
        got.ch1  = m_axis_tdata[15:8];
        got.ch2  = m_axis_tdata[23:16];
        got.row  = m_axis_tdata[35:24];
        got.col  = m_axis_tdata[45:36];
        got.last = m_axis_tlast;
        word_cnt++;
        if (blur_expect_q.size() == 0) begin
            fail_cnt++;
            $display("%0t: unexpected word ch %0d/%0d/%0d row %0d col %0d last %0b",
                     $time, got.ch0, got.ch1, got.ch2, got.row, got.col, got.last);
        end else begin
            want = blur_expect_q.pop_front();
            if (want.last) frame_cnt++;
            if (got.ch0 != want.ch0 || got.ch1 != want.ch1 || got.ch2 != want.ch2 ||
                got.row != want.row || got.col != want.col || got.last != want.last) begin
                fail_cnt++;
                $display("%0t: mismatch expected ch %0d/%0d/%0d row %0d col %0d last %0b",
                         $time, want.ch0, want.ch1, want.ch2, want.row, want.col, want.last);
                $display("%0t:          actual   ch %0d/%0d/%0d row %0d col %0d last %0b",
                         $time, got.ch0, got.ch1, got.ch2, got.row, got.col, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            win_c1     = '{default: '0};
            win_c2     = '{default: '0};
            pos_row    = '0;
            pos_col    = 0;
            blur_expect_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_word();
            if (s_axis_tvalid && s_axis_tready) advance_blur(t_pix'(s_axis_tdata));
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[WIDTH_W-1:0];
                end else begin
                    height_reg = i_cfg_data[HEIGHT_W-1:0];
                end
            end
        end
        o_fail_count  <= fail_cnt;
        o_pending     <= blur_expect_q.size();
        o_word_count  <= word_cnt;
        o_frame_count <= frame_cnt;
    end

endmodule

// ===== dv/tb_box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// Testbench top for box_blur_3x3_rgb: drives config writes, pixel frames and output
// back-pressure, and gives the verdict. Depends on bb3_pkg, box_blur_3x3_rgb and box_blur_checker.
module tb_box_blur_3x3_rgb;
    import bb3_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 400;
    localparam int IDLE_PCT      = 29;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_index   = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [PIX_W-1:0]   s_axis_tdata  = '0;    // in_ch0, in_ch1, in_ch2
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [47:0]        m_axis_tdata;          // out_ch0, out_ch1, out_ch2,
                                               // out_row, out_col, zero pad
    logic               m_axis_tlast;          // frame_last

    int                 chk_fail_count;
    int                 chk_pending;
    int                 chk_word_count;
    int                 chk_frame_count;

    bit                 src_idle_on   = 1'b1;
    bit                 sink_idle_on  = 1'b1;
    int unsigned        sink_hold_req = 0;
    bit                 sink_hold_done = 1'b0;
    int unsigned        sink_hold_left = 0;
    int unsigned        cycle_count   = 0;
    int                 pixels_sent   = 0;

    box_blur_3x3_rgb uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    box_blur_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (chk_fail_count),
        .o_pending     (chk_pending),
        .o_word_count  (chk_word_count),
        .o_frame_count (chk_frame_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_box_blur_3x3_rgb failed");
            $finish;
        end
    end

    // output side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold_left != 0) begin
            m_axis_tready  <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end else if (sink_hold_req != 0 && !sink_hold_done) begin
            m_axis_tready  <= 1'b0;
            sink_hold_left <= sink_hold_req;
            sink_hold_done <= 1'b1;
        end else begin
            m_axis_tready <= !(sink_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic t_pix rand_pixel();
        t_pix px;
        case ($urandom_range(7))
            0: px = '0;
            1: px = '1;
            default: px = t_pix'(PIX_W'($urandom));
        endcase
        return px;
    endfunction

    function automatic int unsigned clamp_size(input int unsigned val, input int unsigned hi);
        if (val < 3) return 3;
        if (val > hi) return hi;
        return val;
    endfunction

    task automatic send_pixel(input t_pix px);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= PIX_W'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int unsigned n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // hold input until every expected word is out, then let the pipeline settle
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // full frame from the top-left; with cut, resize the height part way through
    task automatic run_frame(input int unsigned w_val, input int unsigned h_val, input bit cut);
        int unsigned w, h, r, c0, h2, h2e, n_left;
        w = clamp_size(w_val & 12'h7FF, MAX_WIDTH);
        h = clamp_size(h_val, 4095);
        write_reg(REG_FRAME_WIDTH, w_val);
        write_reg(REG_FRAME_HEIGHT, h_val);
        n_left = w * h;
        if (cut) begin
            r  = $urandom_range(h - 1);
            c0 = $urandom_range(w - 1);
            send_pixels(r * w + c0);
            drain_and_settle();
            h2  = $urandom_range(12);
            h2e = clamp_size(h2, 4095);
            write_reg(REG_FRAME_HEIGHT, h2);
            n_left = (r >= h2e) ? 1 : (h2e - r) * w - c0;
        end
        send_pixels(n_left);
        drain_and_settle();
    endtask

    initial begin
        t_pix px;
        int   start_px;
        int   i;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, all channels saturated; sizes below range clamp to 3
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 1);
        repeat (9) send_pixel('1);
        drain_and_settle();

        // truncation at both ends of the range; width bit above the register dropped
        write_reg(REG_FRAME_WIDTH, 12'h802);
        write_reg(REG_FRAME_HEIGHT, 2);
        for (i = 0; i < 9; i++) begin
            px.ch0 = (i == 4) ? 8'd254 : 8'd255;
            px.ch1 = (i == 8) ? 8'd8 : 8'd0;
            px.ch2 = CH_W'(i * 31);
            send_pixel(px);
        end
        drain_and_settle();

        // tallest frame, cut short by a height write in mid-frame
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 4095);
        send_pixels(15);
        drain_and_settle();
        write_reg(REG_FRAME_HEIGHT, 4);
        send_pixels(1);
        drain_and_settle();

        // width shrunk in mid-frame past the current column
        write_reg(REG_FRAME_WIDTH, 40);
        write_reg(REG_FRAME_HEIGHT, 6);
        send_pixels(106);
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, 8);
        send_pixels(25);
        drain_and_settle();

        // long output hold-off while input keeps coming
        sink_hold_req = 300;
        run_frame(10, 12, 1'b0);

        start_px = pixels_sent;
        while (pixels_sent - start_px < RANDOM_PIXELS) begin
            run_frame(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 14),
                      ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10),
                      $urandom_range(7) == 0);
        end

        // widest row, above range so clamped, then narrowed between rows; no idling at all
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_reg(REG_FRAME_WIDTH, 2047);
        write_reg(REG_FRAME_HEIGHT, 3);
        send_pixels(MAX_WIDTH);
        drain_and_settle();
        write_reg(REG_FRAME_WIDTH, 3);
        send_pixels(6);
        drain_and_settle();

        $display("Run covered %0d pixels in frames from 3x3 up to 4095 tall, rows up to 1024 wide,",
                 pixels_sent);
        $display("with mid-frame resizing and back-pressure: %0d words checked, %0d frame ends.",
                 chk_word_count, chk_frame_count);
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("tb_box_blur_3x3_rgb passed");
        end else begin
            $display("tb_box_blur_3x3_rgb failed");
        end
        $finish;
    end

endmodule
